// ===== hdl/tsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tsm_pkg
// shared types and constants of the tetrahedron stiffness matrix core
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int FIELD_W         = 32;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int NUM_ROWS        = 4;
    localparam int ROW_W           = 2;
    localparam int QUOT_W          = 32;
    localparam int MUL_LAT         = 2;
    localparam int DIV_LAT         = QUOT_W + 2;

    localparam logic [ROW_W-1:0] FIRST_ROW = 2'd0;
    localparam logic [ROW_W-1:0] LAST_ROW  = 2'd3;

    typedef struct packed {
        logic signed [FIELD_W-1:0] v0_x;
        logic signed [FIELD_W-1:0] v0_y;
        logic signed [FIELD_W-1:0] v0_z;
        logic signed [FIELD_W-1:0] v1_x;
        logic signed [FIELD_W-1:0] v1_y;
        logic signed [FIELD_W-1:0] v1_z;
        logic signed [FIELD_W-1:0] v2_x;
        logic signed [FIELD_W-1:0] v2_y;
        logic signed [FIELD_W-1:0] v2_z;
        logic signed [FIELD_W-1:0] v3_x;
        logic signed [FIELD_W-1:0] v3_y;
        logic signed [FIELD_W-1:0] v3_z;
    } t_in_item;

    typedef struct packed {
        logic        [ROW_W-1:0]   row_index;
        logic signed [FIELD_W-1:0] entry_col0;
        logic signed [FIELD_W-1:0] entry_col1;
        logic signed [FIELD_W-1:0] entry_col2;
        logic signed [FIELD_W-1:0] entry_col3;
        logic                      singular;
        logic                      last_row;
    } t_out_item;

    typedef struct packed {
        logic valid;
        logic sing;
        logic neg;
    } t_geom_ctl;

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
        logic             sing;
        logic             neg;
    } t_row_ctl;

endpackage

// ===== hdl/tsm_mul.sv =====
// ----------------------------------------------------------------------------
// tsm_mul
// signed multiplier split into four partial products, two register stages
// ----------------------------------------------------------------------------
module tsm_mul #(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);
    localparam int HA = WA / 2;
    localparam int HB = WB / 2;
    localparam int WP = WA + WB;

    logic signed [WA-HA-1:0] w_ah;
    logic signed [HA:0]      w_al;
    logic signed [WB-HB-1:0] w_bh;
    logic signed [HB:0]      w_bl;

    logic signed [WA-HA+WB-HB-1:0] r_hh;
    logic signed [WA-HA+HB:0]      r_hl;
    logic signed [HA+WB-HB:0]      r_lh;
    logic signed [HA+HB+1:0]       r_ll;

    assign w_ah = i_a[WA-1:HA];
    assign w_al = $signed({1'b0, i_a[HA-1:0]});
    assign w_bh = i_b[WB-1:HB];
    assign w_bl = $signed({1'b0, i_b[HB-1:0]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= w_ah * w_bh;
            r_hl <= w_ah * w_bl;
            r_lh <= w_al * w_bh;
            r_ll <= w_al * w_bl;
            o_p  <= (WP'(r_hh) <<< (HA + HB)) + (WP'(r_hl) <<< HA)
                  + (WP'(r_lh) <<< HB) + WP'(r_ll);
        end
    end

endmodule

// ===== hdl/tsm_geom.sv =====
// ----------------------------------------------------------------------------
// tsm_geom
// jacobian differences, cofactors, determinant and mapped gradients
// ----------------------------------------------------------------------------
module tsm_geom #(
    parameter int CW = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  tsm_pkg::t_in_item         i_item,
    output tsm_pkg::t_geom_ctl        o_ctl,
    output logic signed [2*CW+4:0]    o_g [0:3][0:2],
    output logic        [3*CW+7:0]    o_absden
);
    import tsm_pkg::*;

    localparam int WD   = CW + 1;
    localparam int WC   = 2 * WD + 1;
    localparam int WG   = WC + 2;
    localparam int WDET = WD + WC + 2;
    localparam int WDN  = WDET + 2;

    logic signed [CW-1:0]      w_c [0:3][0:2];
    logic signed [WD-1:0]      r_a [0:8];
    logic signed [WD-1:0]      r_a0_2 [0:2];
    logic signed [WD-1:0]      r_a0_3 [0:2];
    logic signed [WD-1:0]      r_a0_4 [0:2];
    logic signed [WD-1:0]      w_ma [0:17];
    logic signed [WD-1:0]      w_mb [0:17];
    logic signed [2*WD-1:0]    w_pr [0:17];
    logic signed [WC-1:0]      r_adj [0:8];
    logic signed [WD+WC-1:0]   w_dp [0:2];
    logic signed [WG-1:0]      r_g5 [0:3][0:2];
    logic signed [WG-1:0]      r_g6 [0:3][0:2];
    logic signed [WG-1:0]      r_g7 [0:3][0:2];
    logic signed [WDET-1:0]    r_det;
    logic        [WDET-1:0]    w_absdet;
    logic        [7:1]         r_v;

    // signed coordinates, bits above CW dropped
    assign w_c[0][0] = i_item.v0_x[CW-1:0];
    assign w_c[0][1] = i_item.v0_y[CW-1:0];
    assign w_c[0][2] = i_item.v0_z[CW-1:0];
    assign w_c[1][0] = i_item.v1_x[CW-1:0];
    assign w_c[1][1] = i_item.v1_y[CW-1:0];
    assign w_c[1][2] = i_item.v1_z[CW-1:0];
    assign w_c[2][0] = i_item.v2_x[CW-1:0];
    assign w_c[2][1] = i_item.v2_y[CW-1:0];
    assign w_c[2][2] = i_item.v2_z[CW-1:0];
    assign w_c[3][0] = i_item.v3_x[CW-1:0];
    assign w_c[3][1] = i_item.v3_y[CW-1:0];
    assign w_c[3][2] = i_item.v3_z[CW-1:0];

    // r_a index is coord*3 + vertex
    always_comb begin
        w_ma[0]  = r_a[4]; w_mb[0]  = r_a[8];
        w_ma[1]  = r_a[7]; w_mb[1]  = r_a[5];
        w_ma[2]  = r_a[2]; w_mb[2]  = r_a[7];
        w_ma[3]  = r_a[8]; w_mb[3]  = r_a[1];
        w_ma[4]  = r_a[1]; w_mb[4]  = r_a[5];
        w_ma[5]  = r_a[4]; w_mb[5]  = r_a[2];
        w_ma[6]  = r_a[5]; w_mb[6]  = r_a[6];
        w_ma[7]  = r_a[8]; w_mb[7]  = r_a[3];
        w_ma[8]  = r_a[0]; w_mb[8]  = r_a[8];
        w_ma[9]  = r_a[6]; w_mb[9]  = r_a[2];
        w_ma[10] = r_a[2]; w_mb[10] = r_a[3];
        w_ma[11] = r_a[5]; w_mb[11] = r_a[0];
        w_ma[12] = r_a[3]; w_mb[12] = r_a[7];
        w_ma[13] = r_a[6]; w_mb[13] = r_a[4];
        w_ma[14] = r_a[1]; w_mb[14] = r_a[6];
        w_ma[15] = r_a[7]; w_mb[15] = r_a[0];
        w_ma[16] = r_a[0]; w_mb[16] = r_a[4];
        w_ma[17] = r_a[3]; w_mb[17] = r_a[1];
    end

    for (genvar m = 0; m < 18; m++) begin : g_cof_mul
        tsm_mul #(.WA(WD), .WB(WD)) u_mul (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (w_ma[m]),
            .i_b   (w_mb[m]),
            .o_p   (w_pr[m])
        );
    end

    for (genvar v = 0; v < 3; v++) begin : g_det_mul
        tsm_mul #(.WA(WD), .WB(WC)) u_mul (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (r_a0_4[v]),
            .i_b   (r_adj[v*3]),
            .o_p   (w_dp[v])
        );
    end

    assign w_absdet = r_det[WDET-1] ? WDET'(-r_det) : WDET'(r_det);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                for (int v = 0; v < 3; v++) begin
                    r_a[c*3+v] <= WD'(w_c[v][c]) - WD'(w_c[3][c]);
                end
            end
            for (int v = 0; v < 3; v++) begin
                r_a0_2[v] <= r_a[v];
                r_a0_3[v] <= r_a0_2[v];
                r_a0_4[v] <= r_a0_3[v];
            end
            for (int k = 0; k < 9; k++) begin
                r_adj[k] <= WC'(w_pr[2*k]) - WC'(w_pr[2*k+1]);
            end
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_g5[i][k] <= WG'(r_adj[i*3+k]);
                end
                r_g5[3][k] <= -(WG'(r_adj[k]) + WG'(r_adj[3+k]) + WG'(r_adj[6+k]));
            end
            r_g6  <= r_g5;
            r_g7  <= r_g6;
            r_det <= WDET'(w_dp[0]) + WDET'(w_dp[1]) + WDET'(w_dp[2]);
            o_g   <= r_g7;
            // 6 * |det| as two shifted adds
            o_absden  <= (WDN'(w_absdet) << 2) + (WDN'(w_absdet) << 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            o_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_v         <= {r_v[6:1], i_valid};
            o_ctl.valid <= r_v[7];
            o_ctl.sing  <= (r_det == '0);
            o_ctl.neg   <= r_det[WDET-1];
        end
    end

endmodule

// ===== hdl/tsm_div.sv =====
// ----------------------------------------------------------------------------
// tsm_div
// pipelined restoring divider, round half away from zero, saturate to 32 bits
// ----------------------------------------------------------------------------
module tsm_div #(
    parameter int WP  = 140,
    parameter int WDN = 104
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [WP-1:0]       i_p,
    input  logic        [WDN-1:0]      i_absden,
    input  logic                       i_neg,
    output logic signed [tsm_pkg::FIELD_W-1:0] o_entry
);
    import tsm_pkg::*;

    localparam int WN  = WP + 2;
    localparam int WM  = WDN + 1;
    localparam int WT0 = (WN > WM + QUOT_W) ? WN : WM + QUOT_W;
    localparam int WT  = WT0 + 1;

    logic [WP-1:0]     w_absp;
    logic [WN-1:0]     w_n0;
    logic [WM-1:0]     w_m0;
    logic [WN-1:0]     r_n   [0:QUOT_W];
    logic [WM-1:0]     r_m   [0:QUOT_W];
    logic [QUOT_W-1:0] r_q   [0:QUOT_W];
    logic              r_neg [0:QUOT_W];
    logic              r_ovf [0:QUOT_W];
    logic [QUOT_W:0]   w_q;

    assign w_absp = i_p[WP-1] ? WP'(-i_p) : WP'(i_p);
    assign w_n0   = (WN'(w_absp) << 1) + WN'(i_absden);
    assign w_m0   = WM'(i_absden) << 1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]   <= w_n0;
            r_m[0]   <= w_m0;
            r_q[0]   <= '0;
            r_neg[0] <= i_p[WP-1] ^ i_neg;
            r_ovf[0] <= WT'(w_n0) >= (WT'(w_m0) << QUOT_W);
        end
    end

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        localparam int B = QUOT_W - 1 - k;
        logic [WT-1:0] w_t;
        logic          w_ge;
        assign w_t  = WT'(r_m[k]) << B;
        assign w_ge = WT'(r_n[k]) >= w_t;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k+1]   <= w_ge ? WN'(WT'(r_n[k]) - w_t) : r_n[k];
                r_q[k+1]   <= w_ge ? (r_q[k] | (QUOT_W'(1) << B)) : r_q[k];
                r_m[k+1]   <= r_m[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    assign w_q = r_ovf[QUOT_W] ? {1'b1, {QUOT_W{1'b0}}} : {1'b0, r_q[QUOT_W]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_neg[QUOT_W]) begin
                o_entry <= (w_q > (QUOT_W+1)'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                              : $signed(w_q[QUOT_W-1:0]);
            end else begin
                o_entry <= (w_q > (QUOT_W+1)'(32'h8000_0000)) ? 32'sh8000_0000
                                                              : $signed(-w_q[QUOT_W-1:0]);
            end
        end
    end

endmodule

// ===== hdl/p1_tet_stiffness_matrix_core.sv =====
// ----------------------------------------------------------------------------
// p1_tet_stiffness_matrix_core
// 4x4 laplace stiffness matrix of a linear tetrahedron, one row per item out
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  input   | in        | i_valid / o_stall  | t_in_item, four vertices q16.16
//  output  | out       | o_valid / i_stall  | t_out_item, one matrix row
//
//  the geometry stage takes a new element while the row sequencer is free or
//  on its last row; the sequencer issues the four rows of a held element, one
//  a cycle unless the output stalls, into the dot product and divider lanes
//  rows pass geometry, sequencing, multiply, sum, division and output register
//  reset clears valid, sequencer row and control regs; datapath regs left as is
//  a stall on a held output row freezes the whole pipeline, nothing is dropped
//
module p1_tet_stiffness_matrix_core #(
    parameter int COORD_WIDTH = tsm_pkg::COORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  tsm_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output tsm_pkg::t_out_item o_item
);
    import tsm_pkg::*;

    // coordinates wider than the field are the field itself
    localparam int CW   = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
    localparam int WD   = CW + 1;
    localparam int WC   = 2 * WD + 1;
    localparam int WG   = WC + 2;
    localparam int WDET = WD + WC + 2;
    localparam int WDN  = WDET + 2;
    localparam int WP   = 2 * WG + 2;
    localparam int CTL_DEPTH = MUL_LAT + DIV_LAT + 1;

    logic en;
    logic en_a;

    t_geom_ctl            w_gctl;
    logic signed [WG-1:0] w_g [0:3][0:2];
    logic [WDN-1:0]       w_absden;

    // row sequencer
    logic                 r_seq_valid;
    logic [ROW_W-1:0]     r_seq_row;
    logic signed [WG-1:0] r_seq_g [0:3][0:2];
    logic [WDN-1:0]       r_seq_absden;
    logic                 r_seq_sing;
    logic                 r_seq_neg;

    logic signed [WG-1:0]   w_gi [0:2];
    logic signed [2*WG-1:0] w_prod [0:3][0:2];
    logic signed [WP-1:0]   r_p [0:3];
    logic [WDN-1:0]         r_absden [0:MUL_LAT];
    t_row_ctl               r_ctl [0:CTL_DEPTH-1];
    logic signed [FIELD_W-1:0] w_entry [0:3];

    logic r_out_valid;

    // whole pipeline moves unless a finished row is held
    assign en   = !(r_out_valid && i_stall);
    // geometry moves when the sequencer is free or on its last row
    assign en_a = en && (!r_seq_valid || (r_seq_row == LAST_ROW));

    assign o_stall = !en_a;
    assign o_valid = r_out_valid;

    tsm_geom #(.CW(CW)) u_geom (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en_a),
        .i_valid  (i_valid),
        .i_item   (i_item),
        .o_ctl    (w_gctl),
        .o_g      (w_g),
        .o_absden (w_absden)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_valid <= 1'b0;
            r_seq_row   <= FIRST_ROW;
        end else if (en) begin
            if (r_seq_valid && (r_seq_row != LAST_ROW)) begin
                r_seq_row <= r_seq_row + 1'b1;
            end else begin
                r_seq_valid <= w_gctl.valid;
                r_seq_row   <= FIRST_ROW;
            end
        end
    end

    // element data load with the sequencer restart
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_seq_g      <= w_g;
            r_seq_absden <= w_absden;
            r_seq_sing   <= w_gctl.sing;
            r_seq_neg    <= w_gctl.neg;
        end
    end

    assign w_gi = r_seq_g[r_seq_row];

    // dot products g_row . g_j, one lane per column
    for (genvar j = 0; j < 4; j++) begin : g_lane
        for (genvar k = 0; k < 3; k++) begin : g_comp
            tsm_mul #(.WA(WG), .WB(WG)) u_mul (
                .i_clk (i_clk),
                .i_en  (en),
                .i_a   (w_gi[k]),
                .i_b   (r_seq_g[j][k]),
                .o_p   (w_prod[j][k])
            );
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_p[j] <= WP'(w_prod[j][0]) + WP'(w_prod[j][1]) + WP'(w_prod[j][2]);
            end
        end

        tsm_div #(.WP(WP), .WDN(WDN)) u_div (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_p      (r_p[j]),
            .i_absden (r_absden[MUL_LAT]),
            .i_neg    (r_ctl[MUL_LAT].neg),
            .o_entry  (w_entry[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_absden[0] <= r_seq_absden;
            for (int s = 1; s <= MUL_LAT; s++) begin
                r_absden[s] <= r_absden[s-1];
            end
        end
    end

    // control travels alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < CTL_DEPTH; s++) begin
                r_ctl[s] <= '0;
            end
        end else if (en) begin
            r_ctl[0].valid <= r_seq_valid;
            r_ctl[0].row   <= r_seq_row;
            r_ctl[0].sing  <= r_seq_sing;
            r_ctl[0].neg   <= r_seq_neg;
            for (int s = 1; s < CTL_DEPTH; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    // output register, singular elements give zero entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_ctl[CTL_DEPTH-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_item.row_index  <= r_ctl[CTL_DEPTH-1].row;
            o_item.entry_col0 <= r_ctl[CTL_DEPTH-1].sing ? '0 : w_entry[0];
            o_item.entry_col1 <= r_ctl[CTL_DEPTH-1].sing ? '0 : w_entry[1];
            o_item.entry_col2 <= r_ctl[CTL_DEPTH-1].sing ? '0 : w_entry[2];
            o_item.entry_col3 <= r_ctl[CTL_DEPTH-1].sing ? '0 : w_entry[3];
            o_item.singular   <= r_ctl[CTL_DEPTH-1].sing;
            o_item.last_row   <= (r_ctl[CTL_DEPTH-1].row == LAST_ROW);
        end
    end

    // input held while a loaded element still has rows to issue
    a_seq_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_valid && (r_seq_row != LAST_ROW)) |-> o_stall)
        else $error("input taken while rows pending");

    // singular rows carry zero entries
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.singular) |->
        ((o_item.entry_col0 == '0) && (o_item.entry_col1 == '0) &&
         (o_item.entry_col2 == '0) && (o_item.entry_col3 == '0)))
        else $error("singular row with nonzero entry");

    // row numbering advances one per delivered row
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_item.last_row) |=>
        (!o_valid || (o_item.row_index == $past(o_item.row_index) + 2'd1)))
        else $error("row order broken");

endmodule

// ===== sim/tsm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_checker
// watches both channels, predicts the four stiffness rows of every accepted
// element and compares each output row field by field, oldest first
// ----------------------------------------------------------------------------
module tsm_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  tsm_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  tsm_pkg::t_out_item i_out_item,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_rows_seen,
    output int                 o_sing_seen,
    output int                 o_sat_seen
);
    import tsm_pkg::*;

    t_out_item expected_rows[$];

    // rounded quotient, half away from zero, clamped to signed 32 bits
    function automatic logic signed [31:0] round_div_sat(
        input logic signed [255:0] num, input logic signed [255:0] den);
        logic signed [255:0] an, ad, q;
        logic                neg;
        an  = (num < 0) ? -num : num;
        ad  = (den < 0) ? -den : den;
        neg = (num < 0) != (den < 0);
        q   = (2 * an + ad) / (2 * ad);
        if (!neg) begin
            if (q > 256'sh7FFFFFFF) q = 256'sh7FFFFFFF;
            return q[31:0];
        end
        if (q > 256'sh80000000) q = 256'sh80000000;
        return -q[31:0];
    endfunction

    task automatic predict_rows(input t_in_item it);
        logic signed [255:0] jac[3][3], cof[3][3], grad[4][3], det, dotp;
        logic signed [255:0] vtx[4][3];
        t_out_item           row;
        vtx[0] = '{it.v0_x, it.v0_y, it.v0_z};
        vtx[1] = '{it.v1_x, it.v1_y, it.v1_z};
        vtx[2] = '{it.v2_x, it.v2_y, it.v2_z};
        vtx[3] = '{it.v3_x, it.v3_y, it.v3_z};
        for (int c = 0; c < 3; c++)
            for (int v = 0; v < 3; v++)
                jac[c][v] = vtx[v][c] - vtx[3][c];
        cof[0][0] = jac[1][1]*jac[2][2] - jac[2][1]*jac[1][2];
        cof[0][1] = jac[0][2]*jac[2][1] - jac[2][2]*jac[0][1];
        cof[0][2] = jac[0][1]*jac[1][2] - jac[1][1]*jac[0][2];
        cof[1][0] = jac[1][2]*jac[2][0] - jac[2][2]*jac[1][0];
        cof[1][1] = jac[0][0]*jac[2][2] - jac[2][0]*jac[0][2];
        cof[1][2] = jac[0][2]*jac[1][0] - jac[1][2]*jac[0][0];
        cof[2][0] = jac[1][0]*jac[2][1] - jac[2][0]*jac[1][1];
        cof[2][1] = jac[0][1]*jac[2][0] - jac[2][1]*jac[0][0];
        cof[2][2] = jac[0][0]*jac[1][1] - jac[1][0]*jac[0][1];
        det = jac[0][0]*cof[0][0] + jac[0][1]*cof[1][0] + jac[0][2]*cof[2][0];
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) grad[i][k] = cof[i][k];
            grad[3][k] = -(cof[0][k] + cof[1][k] + cof[2][k]);
        end
        for (int i = 0; i < 4; i++) begin
            row = '0;
            row.row_index = i[1:0];
            row.singular  = (det == 0);
            row.last_row  = (i == 3);
            for (int j = 0; j < 4; j++) begin
                logic signed [31:0] e;
                e = '0;
                if (det != 0) begin
                    dotp = grad[i][0]*grad[j][0] + grad[i][1]*grad[j][1]
                         + grad[i][2]*grad[j][2];
                    e = round_div_sat(dotp, det * 6);
                end
                case (j)
                    0: row.entry_col0 = e;
                    1: row.entry_col1 = e;
                    2: row.entry_col2 = e;
                    default: row.entry_col3 = e;
                endcase
            end
            expected_rows.push_back(row);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_errors    <= 0;
            o_rows_seen <= 0;
            o_sing_seen <= 0;
            o_sat_seen  <= 0;
            o_pending   <= expected_rows.size();
        end else begin
            if (i_valid && !i_in_stall) predict_rows(i_in_item);
            if (i_out_valid && !i_out_stall) begin
                o_rows_seen <= o_rows_seen + 1;
                if (i_out_item.singular) o_sing_seen <= o_sing_seen + 1;
                if (i_out_item.entry_col0 == 32'sh7FFFFFFF ||
                    i_out_item.entry_col0 == 32'sh80000000)
                    o_sat_seen <= o_sat_seen + 1;
                if (expected_rows.size() == 0) begin
                    $display("%0t: unexpected row, actual %h", $time, i_out_item);
                    o_errors <= o_errors + 1;
                end else begin
                    t_out_item exp_row;
                    exp_row = expected_rows.pop_front();
                    if (exp_row !== i_out_item) begin
                        $display("%0t: row mismatch, expected %h actual %h",
                                 $time, exp_row, i_out_item);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= expected_rows.size();
        end
    end

endmodule

// ===== sim/p1_tet_stiffness_matrix_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1_tet_stiffness_matrix_core_tb
// drives tetrahedra into the stiffness core with random gaps and output
// stalls, including one long output hold-off; the checker scores the rows
// ----------------------------------------------------------------------------
module p1_tet_stiffness_matrix_core_tb;
    import tsm_pkg::*;

    localparam int LATENCY    = 47;
    localparam int NUM_RANDOM = 390;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    int errors, pending, rows_seen, sing_seen, sat_seen;
    int elements_sent;
    bit stim_done;
    bit long_hold;

    p1_tet_stiffness_matrix_core i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_item (i_item),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_item (o_item)
    );

    tsm_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_in_stall (o_stall),
        .i_in_item  (i_item),
        .i_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_out_item (o_item),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_rows_seen(rows_seen),
        .o_sing_seen(sing_seen),
        .o_sat_seen (sat_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // gap length: mostly zero or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // random coordinate: small, mid or full range values
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            1: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 32'h0000_0400)) - 32'sh200;
        endcase
    endfunction

    function automatic t_in_item rand_tet();
        t_in_item t;
        int       kind;
        t = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        kind = $urandom_range(0, 9);
        // degenerate: vertex 2 copies vertex 0, so det is zero
        if (kind == 0) begin
            t.v2_x = t.v0_x; t.v2_y = t.v0_y; t.v2_z = t.v0_z;
        end
        // coplanar: all z equal
        if (kind == 1) begin
            t.v1_z = t.v0_z; t.v2_z = t.v0_z; t.v3_z = t.v0_z;
        end
        return t;
    endfunction

    function automatic t_in_item make_tet(input logic signed [31:0] s,
                                          input logic signed [31:0] o,
                                          input bit flip);
        t_in_item t;
        t = '0;
        t.v3_x = o; t.v3_y = o; t.v3_z = o;
        t.v0_x = o + s; t.v0_y = o; t.v0_z = o;
        t.v1_x = o; t.v1_y = o + s; t.v1_z = o;
        t.v2_x = o; t.v2_y = o; t.v2_z = flip ? o - s : o + s;
        return t;
    endfunction

    // hold each item until the core accepts it, after a random gap
    task automatic send_tet(input t_in_item t);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= t;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        elements_sent++;
    endtask

    // receiver stall: random bursts, plus one long hold while inputs pile up
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        i_stall   = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold && !hold_done) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_done = 1'b1;
            end
            i_stall <= ($urandom_range(0, 3) == 0);
            @(posedge i_clk);
            if ($urandom_range(0, 40) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end
        end
    end

    initial begin
        t_in_item t;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_item        = '0;
        elements_sent = 0;
        stim_done     = 1'b0;
        long_hold     = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: unit tet, inverted, scaled, offset, degenerate, extremes
        send_tet(make_tet(32'sh0001_0000, 0, 0));
        send_tet(make_tet(32'sh0001_0000, 0, 1));
        send_tet(make_tet(32'sh0000_0001, 0, 0));
        send_tet(make_tet(32'sh0100_0000, 32'sh1000_0000, 0));
        send_tet(make_tet(32'sh0000_8000, -32'sh1000_0000, 1));
        send_tet('0);
        send_tet({12{32'sh7FFF_FFFF}});
        send_tet({12{32'sh8000_0000}});
        t = make_tet(32'sh0001_0000, 0, 0);
        t.v0_x = 32'sh7FFF_FFFF; t.v1_y = 32'sh8000_0000;
        send_tet(t);
        t = '0;
        t.v0_x = 32'sh7FFF_FFFF; t.v1_y = 32'sh7FFF_FFFF; t.v2_z = 32'sh7FFF_FFFF;
        t.v3_x = 32'sh8000_0000; t.v3_y = 32'sh8000_0000; t.v3_z = 32'sh8000_0000;
        send_tet(t);
        // sliver: huge spread, tiny height, saturates entries
        t = make_tet(32'sh4000_0000, 0, 0);
        t.v2_z = 1;
        send_tet(t);
        t = make_tet(32'sh4000_0000, 0, 1);
        t.v2_z = -1;
        send_tet(t);
        // all bits toggled
        send_tet({12{32'hAAAA_AAAA}} ^ {6{64'hFFFF_FFFF_0000_0000}});
        send_tet({12{32'h5555_5555}});

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM / 2) long_hold = 1'b1;
            send_tet(rand_tet());
        end
        i_valid   <= 1'b0;
        stim_done  = 1'b1;
    end

    initial begin
        @(posedge stim_done);
        while (pending != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        $display("%0d elements sent, %0d rows checked", elements_sent, rows_seen);
        $display("%0d singular rows, %0d saturated col0 entries", sing_seen, sat_seen);
        if (errors == 0 && pending == 0)
            $display("p1_tet_stiffness_matrix_core_tb: done, clean");
        else
            $display("p1_tet_stiffness_matrix_core_tb: done, errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("p1_tet_stiffness_matrix_core_tb: done, errors");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/tsm_pkg.sv
hdl/tsm_mul.sv
hdl/tsm_geom.sv
hdl/tsm_div.sv
hdl/p1_tet_stiffness_matrix_core.sv
sim/tsm_checker.sv
sim/p1_tet_stiffness_matrix_core_tb.sv
